/* rtl/gda_pkg.sv */
// gda_pkg: shared types, codes, constants and calendar helper functions
// for the gregorian date arithmetic block; depends on nothing else
`default_nettype none

package gda_pkg;

  localparam int unsigned YEAR_MIN     = 1;
  localparam int unsigned YEAR_MAX     = 9999;
  localparam int unsigned DAYS_YEAR    = 365;
  localparam int unsigned DIV100_MUL   = 5243;  // floor(y / 100) = (y * 5243) >> 19
  localparam int unsigned DIV100_SHIFT = 19;
  localparam int unsigned WEEK_MUL     = 293;   // floor(n / 7) = (n * 293) >> 11
  localparam int unsigned WEEK_SHIFT   = 11;
  localparam int unsigned QUEUE_DEPTH  = 4;
  localparam int unsigned OUT_DEPTH    = 4;

  typedef enum logic [2:0] {
    MODE_NEXT = 3'd0,
    MODE_PREV = 3'd1,
    MODE_YDAY = 3'd2,
    MODE_ORD  = 3'd3,
    MODE_DIFF = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_RANGE   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    MON_JAN = 4'd1,
    MON_FEB = 4'd2,
    MON_MAR = 4'd3,
    MON_APR = 4'd4,
    MON_MAY = 4'd5,
    MON_JUN = 4'd6,
    MON_JUL = 4'd7,
    MON_AUG = 4'd8,
    MON_SEP = 4'd9,
    MON_OCT = 4'd10,
    MON_NOV = 4'd11,
    MON_DEC = 4'd12
  } month_t;

  // classified transaction handed from front to back
  typedef struct packed {
    mode_t       mode;
    logic        bad;
    logic [13:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    logic        leap;
    logic [4:0]  dim_cur;
    logic [4:0]  dim_prev;
    logic [8:0]  yd;
    logic [6:0]  pq;
    logic [13:0] oy;
    logic [8:0]  oyd;
    logic [6:0]  opq;
  } entry_t;

  typedef struct packed {
    logic [13:0] res_year;
    logic [3:0]  res_month;
    logic [4:0]  res_day;
    logic        leap_flag;
    logic [8:0]  day_of_year;
    logic [5:0]  week_number;
    logic [21:0] day_ordinal;
    logic [21:0] days_between;
    status_t     status;
  } result_t;

  function automatic logic is_century(logic [13:0] y, logic [6:0] q);
    logic [13:0] h;
    h = 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
    return y == h;
  endfunction

  function automatic logic is_leap(logic [13:0] y, logic [6:0] q);
    return (y[1:0] == 2'b00) && (!is_century(y, q) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
    logic [4:0] n;
    unique case (m)
      MON_FEB: n = leap ? 5'd29 : 5'd28;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: n = 5'd30;
      MON_JAN, MON_MAR, MON_MAY, MON_JUL, MON_AUG, MON_OCT, MON_DEC: n = 5'd31;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  // days in the months before m, common year
  function automatic logic [8:0] days_before(logic [3:0] m);
    logic [8:0] n;
    unique case (m)
      MON_JAN: n = 9'd0;
      MON_FEB: n = 9'd31;
      MON_MAR: n = 9'd59;
      MON_APR: n = 9'd90;
      MON_MAY: n = 9'd120;
      MON_JUN: n = 9'd151;
      MON_JUL: n = 9'd181;
      MON_AUG: n = 9'd212;
      MON_SEP: n = 9'd243;
      MON_OCT: n = 9'd273;
      MON_NOV: n = 9'd304;
      MON_DEC: n = 9'd334;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

  function automatic logic date_ok(logic [13:0] y, logic [3:0] m, logic [4:0] d,
                                   logic leap);
    return (y >= 14'(YEAR_MIN)) && (y <= 14'(YEAR_MAX)) && (m >= 4'(MON_JAN)) &&
           (m <= 4'(MON_DEC)) && (d >= 5'd1) && (d <= month_len(m, leap));
  endfunction

endpackage

`default_nettype wire

/* rtl/gregorian_date_arithmetic.sv */
// Gregorian calendar date unit: next/previous day, day of year and week,
// day ordinal from 0001-01-01, and day difference between two dates.
//
// Input channel: present mode and the date fields with push; a transaction
// is taken at a rising edge with push high and full low. Result channel:
// while empty is low the oldest result sits on the res_*, leap_flag,
// day_of_year, week_number, day_ordinal, days_between and status ports;
// it is taken at a rising edge with pop high and empty low. Exactly one
// result per input transaction, in order.
// Throughput: one transaction per cycle while the result queue has room, set
// by the front register stage, the two back stages (year times 365, then
// the ordinal sum) and the result queue.
// A front stage checks and classifies items into a small queue; the back
// stages stall once the result queue is full and pop is held low, and
// full rises once the front stage and the input queue are both occupied.
// Reset (rst, synchronous) empties every queue and stage; no other state.
// Fields that a mode does not produce read as zero.
`default_nettype none

module gregorian_date_arithmetic
  import gda_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = gda_pkg::QUEUE_DEPTH,
  parameter int unsigned OUT_DEPTH   = gda_pkg::OUT_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  mode,
  input  wire logic [13:0] year_in,
  input  wire logic [3:0]  month_in,
  input  wire logic [4:0]  day_in,
  input  wire logic [13:0] other_year,
  input  wire logic [3:0]  other_month,
  input  wire logic [4:0]  other_day,
  input  wire logic        pop,
  output logic             empty,
  output logic [13:0]      res_year,
  output logic [3:0]       res_month,
  output logic [4:0]       res_day,
  output logic             leap_flag,
  output logic [8:0]       day_of_year,
  output logic [5:0]       week_number,
  output logic [21:0]      day_ordinal,
  output logic [21:0]      days_between,
  output logic [1:0]       status
);

  logic    q_push;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  entry_t  q_in;
  entry_t  q_out;
  result_t res;

  gda_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .mode       (mode),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .other_year (other_year),
    .other_month(other_month),
    .other_day  (other_day),
    .q_push     (q_push),
    .q_entry    (q_in),
    .q_full     (q_full)
  );

  gda_fifo #(
    .WIDTH($bits(entry_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (q_push),
    .wdata(q_in),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_out),
    .empty(q_empty)
  );

  gda_back #(
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_empty(q_empty),
    .q_entry(q_out),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .res    (res)
  );

  assign res_year     = res.res_year;
  assign res_month    = res.res_month;
  assign res_day      = res.res_day;
  assign leap_flag    = res.leap_flag;
  assign day_of_year  = res.day_of_year;
  assign week_number  = res.week_number;
  assign day_ordinal  = res.day_ordinal;
  assign days_between = res.days_between;
  assign status       = res.status;

endmodule

`default_nettype wire

/* rtl/gda_fifo.sv */
// gda_fifo: small register queue with push/full and pop/empty sides
// no dependencies; DEPTH must be a power of two
`default_nettype none

module gda_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr;
  logic [PW-1:0]    rptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CW'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + PW'(1);
      if (do_pop) rptr <= rptr + PW'(1);
      if (do_push && !do_pop) count <= count + CW'(1);
      else if (do_pop && !do_push) count <= count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= wdata;
  end

endmodule

`default_nettype wire

/* rtl/gda_front.sv */
// gda_front: accepts input transactions, checks dates, derives leap flags,
// day of year and century counts; uses gda_pkg
`default_nettype none

module gda_front
  import gda_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  mode,
  input  wire logic [13:0] year_in,
  input  wire logic [3:0]  month_in,
  input  wire logic [4:0]  day_in,
  input  wire logic [13:0] other_year,
  input  wire logic [3:0]  other_month,
  input  wire logic [4:0]  other_day,
  output logic             q_push,
  output entry_t           q_entry,
  input  wire logic        q_full
);

  logic        a_valid;
  logic [2:0]  a_mode;
  logic [13:0] a_y;
  logic [3:0]  a_m;
  logic [4:0]  a_d;
  logic [13:0] a_oy;
  logic [3:0]  a_om;
  logic [4:0]  a_od;
  logic [6:0]  a_q;
  logic [6:0]  a_oq;

  logic        a_en;
  logic [26:0] prod_y;
  logic [26:0] prod_oy;

  logic        cent;
  logic        ocent;
  logic        leap;
  logic        oleap;
  logic        known;
  logic        ok1;
  logic        ok2;
  logic [3:0]  m_prev;

  assign a_en   = !a_valid || !q_full;
  assign full   = !a_en;
  assign q_push = a_valid && !q_full;

  assign prod_y  = 27'(year_in) * 27'(DIV100_MUL);
  assign prod_oy = 27'(other_year) * 27'(DIV100_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_en) begin
      a_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (a_en && push) begin
      a_mode <= mode;
      a_y    <= year_in;
      a_m    <= month_in;
      a_d    <= day_in;
      a_oy   <= other_year;
      a_om   <= other_month;
      a_od   <= other_day;
      a_q    <= prod_y[DIV100_SHIFT +: 7];
      a_oq   <= prod_oy[DIV100_SHIFT +: 7];
    end
  end

  assign cent   = is_century(a_y, a_q);
  assign ocent  = is_century(a_oy, a_oq);
  assign leap   = is_leap(a_y, a_q);
  assign oleap  = is_leap(a_oy, a_oq);
  assign ok1    = date_ok(a_y, a_m, a_d, leap);
  assign ok2    = date_ok(a_oy, a_om, a_od, oleap);
  assign m_prev = a_m - 4'd1;

  always_comb begin
    unique case (a_mode)
      MODE_NEXT, MODE_PREV, MODE_YDAY, MODE_ORD, MODE_DIFF: known = 1'b1;
      default: known = 1'b0;
    endcase
  end

  always_comb begin
    q_entry.mode     = known ? mode_t'(a_mode) : MODE_NEXT;
    q_entry.bad      = !known || !ok1 || ((a_mode == MODE_DIFF) && !ok2);
    q_entry.y        = a_y;
    q_entry.m        = a_m;
    q_entry.d        = a_d;
    q_entry.leap     = leap;
    q_entry.dim_cur  = month_len(a_m, leap);
    q_entry.dim_prev = month_len(m_prev, leap);
    q_entry.yd       = days_before(a_m) + 9'(a_d)
                       + 9'((a_m > 4'(MON_FEB)) && leap);
    q_entry.pq       = cent ? a_q - 7'd1 : a_q;
    q_entry.oy       = a_oy;
    q_entry.oyd      = days_before(a_om) + 9'(a_od)
                       + 9'((a_om > 4'(MON_FEB)) && oleap);
    q_entry.opq      = ocent ? a_oq - 7'd1 : a_oq;
  end

endmodule

`default_nettype wire

/* rtl/gda_back.sv */
// gda_back: computes next/previous date, day of year and week, ordinals and the
// day difference in two stages, then queues results; uses gda_pkg, gda_fifo
`default_nettype none

module gda_back
  import gda_pkg::*;
#(
  parameter int unsigned OUT_DEPTH = gda_pkg::OUT_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   q_empty,
  input  wire entry_t q_entry,
  output logic        q_pop,
  input  wire logic   pop,
  output logic        empty,
  output result_t     res
);

  entry_t      e;
  logic        en;
  logic        o_full;
  logic        o_push;

  logic        b1_valid;
  result_t     b1_res;
  logic [21:0] b1_pma;
  logic [21:0] b1_pmb;
  logic [12:0] b1_sa;
  logic [12:0] b1_sb;
  mode_t       b1_mode;
  logic        b1_bad;

  logic        b2_valid;
  result_t     b2_res;
  logic [21:0] b2_oa;
  logic [21:0] b2_ob;
  mode_t       b2_mode;
  logic        b2_bad;

  result_t     r1;
  logic [13:0] pa;
  logic [13:0] pb;
  logic [22:0] pma_full;
  logic [22:0] pmb_full;
  logic [16:0] wk_prod;
  result_t     r2;

  assign e     = q_entry;
  assign en    = !(b2_valid && o_full);
  assign q_pop = en && !q_empty;
  assign o_push = b2_valid && !o_full;

  assign pa       = e.y - 14'd1;
  assign pb       = e.oy - 14'd1;
  assign pma_full = 23'(pa) * 23'(DAYS_YEAR);
  assign pmb_full = 23'(pb) * 23'(DAYS_YEAR);
  assign wk_prod  = 17'(e.yd) * 17'(WEEK_MUL);

  always_comb begin
    r1        = '0;
    r1.status = ST_OK;
    if (e.bad) begin
      r1.status = ST_INVALID;
    end else begin
      unique case (e.mode)
        MODE_NEXT: begin
          if (e.d < e.dim_cur) begin
            r1.res_year  = e.y;
            r1.res_month = e.m;
            r1.res_day   = e.d + 5'd1;
          end else if (e.m != 4'(MON_DEC)) begin
            r1.res_year  = e.y;
            r1.res_month = e.m + 4'd1;
            r1.res_day   = 5'd1;
          end else if (e.y >= 14'(YEAR_MAX)) begin
            r1.status = ST_RANGE;
          end else begin
            r1.res_year  = e.y + 14'd1;
            r1.res_month = 4'(MON_JAN);
            r1.res_day   = 5'd1;
          end
        end
        MODE_PREV: begin
          if (e.d > 5'd1) begin
            r1.res_year  = e.y;
            r1.res_month = e.m;
            r1.res_day   = e.d - 5'd1;
          end else if (e.m > 4'(MON_JAN)) begin
            r1.res_year  = e.y;
            r1.res_month = e.m - 4'd1;
            r1.res_day   = e.dim_prev;
          end else if (e.y <= 14'(YEAR_MIN)) begin
            r1.status = ST_RANGE;
          end else begin
            r1.res_year  = e.y - 14'd1;
            r1.res_month = 4'(MON_DEC);
            r1.res_day   = 5'd31;
          end
        end
        MODE_YDAY: begin
          r1.leap_flag   = e.leap;
          r1.day_of_year = e.yd;
          r1.week_number = 6'(wk_prod[WEEK_SHIFT +: 6]) + 6'd1;
        end
        MODE_ORD, MODE_DIFF: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
    end else if (en) begin
      b1_valid <= !q_empty;
      b2_valid <= b1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_res <= r1;
      b1_pma <= pma_full[21:0];
      b1_pmb <= pmb_full[21:0];
      b1_sa  <= 13'(pa >> 2) - 13'(e.pq) + 13'(e.pq >> 2) + 13'(e.yd);
      b1_sb  <= 13'(pb >> 2) - 13'(e.opq) + 13'(e.opq >> 2) + 13'(e.oyd);
      b2_res <= b1_res;
      b2_oa  <= b1_pma + 22'(b1_sa);
      b2_ob  <= b1_pmb + 22'(b1_sb);
    end
  end

  // mode and bad flag ride along to pick the ordinal fields
  always_ff @(posedge clk) begin
    if (en) begin
      b1_mode <= e.mode;
      b1_bad  <= e.bad;
      b2_mode <= b1_mode;
      b2_bad  <= b1_bad;
    end
  end

  always_comb begin
    r2 = b2_res;
    if (!b2_bad && (b2_mode == MODE_ORD)) begin
      r2.day_ordinal = b2_oa;
    end
    if (!b2_bad && (b2_mode == MODE_DIFF)) begin
      r2.days_between = (b2_oa >= b2_ob) ? b2_oa - b2_ob : b2_ob - b2_oa;
    end
  end

  gda_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (o_push),
    .wdata(r2),
    .full (o_full),
    .pop  (pop),
    .rdata(res),
    .empty(empty)
  );

endmodule

`default_nettype wire
